// File: hdl/lmpc_pkg.sv
// Shared types, register map, mode codes and the SOS pattern table of the lamp controller.
package lmpc_pkg;

	localparam int DEF_CHANNELS  = 5;
	localparam int DEF_SOS_STEPS = 18;
	localparam int CFG_ADDR_W    = 5;
	localparam int STEP_W        = 5;
	localparam int PATTERN_LEN   = 18;

	localparam logic [2:0] REG_SINGLE_LIMIT = 3'd0;
	localparam logic [2:0] REG_ALL_LIMIT    = 3'd1;
	localparam logic [2:0] REG_CHASE_STEP   = 3'd2;
	localparam logic [2:0] REG_CHASE_GAP    = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE     = 3'd4;
	localparam logic [2:0] REG_REFRESH      = 3'd5;
	localparam logic [2:0] REG_DOT          = 3'd6;
	localparam logic [2:0] REG_DASH         = 3'd7;

	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_ALL    = 2'd1;
	localparam logic [1:0] MODE_CHASE  = 2'd2;
	localparam logic [1:0] MODE_SOS    = 2'd3;

	localparam logic [1:0] KIND_DOT  = 2'd0;
	localparam logic [1:0] KIND_DASH = 2'd1;
	localparam logic [1:0] KIND_WORD = 2'd2;

	localparam logic [15:0] WORD_PAUSE_MS = 16'd4000;
	localparam logic [5:0]  LEVEL_RESET   = 6'd4;

	localparam logic [5:0]  RST_SINGLE_LIMIT = 6'd63;
	localparam logic [5:0]  RST_ALL_LIMIT    = 6'd44;
	localparam logic [9:0]  RST_CHASE_STEP   = 10'd100;
	localparam logic [11:0] RST_CHASE_GAP    = 12'd500;
	localparam logic [9:0]  RST_DEBOUNCE     = 10'd100;
	localparam logic [7:0]  RST_REFRESH      = 8'd5;
	localparam logic [11:0] RST_DOT          = 12'd300;
	localparam logic [11:0] RST_DASH         = 12'd900;

	typedef struct packed {
		logic [5:0]  single_limit;
		logic [5:0]  all_limit;
		logic [9:0]  chase_step_ms;
		logic [11:0] chase_gap_ms;
		logic [9:0]  debounce_ms;
		logic [7:0]  refresh_ms;
		logic [11:0] dot_ms;
		logic [11:0] dash_ms;
	} cfg_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [1:0] sos_kind(input logic [STEP_W-1:0] idx);
		logic [STEP_W-1:0] pos;
		logic [1:0] kind;
		pos = (idx >= STEP_W'(PATTERN_LEN)) ? idx - STEP_W'(PATTERN_LEN) : idx;
		case (pos)
			5'd5, 5'd6, 5'd8, 5'd10, 5'd11: kind = KIND_DASH;
			5'd17: kind = KIND_WORD;
			default: kind = KIND_DOT;
		endcase
		return kind;
	endfunction

endpackage

// File: hdl/lmpc_regs.sv
// Configuration register file with its APB-style write and read access.
module lmpc_regs import lmpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[CFG_ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_limit  <= RST_SINGLE_LIMIT;
			cfg_q.all_limit     <= RST_ALL_LIMIT;
			cfg_q.chase_step_ms <= RST_CHASE_STEP;
			cfg_q.chase_gap_ms  <= RST_CHASE_GAP;
			cfg_q.debounce_ms   <= RST_DEBOUNCE;
			cfg_q.refresh_ms    <= RST_REFRESH;
			cfg_q.dot_ms        <= RST_DOT;
			cfg_q.dash_ms       <= RST_DASH;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_SINGLE_LIMIT: cfg_q.single_limit  <= pwdata[5:0];
				REG_ALL_LIMIT:    cfg_q.all_limit     <= pwdata[5:0];
				REG_CHASE_STEP:   cfg_q.chase_step_ms <= pwdata[9:0];
				REG_CHASE_GAP:    cfg_q.chase_gap_ms  <= pwdata[11:0];
				REG_DEBOUNCE:     cfg_q.debounce_ms   <= pwdata[9:0];
				REG_REFRESH:      cfg_q.refresh_ms    <= pwdata[7:0];
				REG_DOT:          cfg_q.dot_ms        <= pwdata[11:0];
				REG_DASH:         cfg_q.dash_ms       <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SINGLE_LIMIT: prdata = {26'd0, cfg_q.single_limit};
			REG_ALL_LIMIT:    prdata = {26'd0, cfg_q.all_limit};
			REG_CHASE_STEP:   prdata = {22'd0, cfg_q.chase_step_ms};
			REG_CHASE_GAP:    prdata = {20'd0, cfg_q.chase_gap_ms};
			REG_DEBOUNCE:     prdata = {22'd0, cfg_q.debounce_ms};
			REG_REFRESH:      prdata = {24'd0, cfg_q.refresh_ms};
			REG_DOT:          prdata = {20'd0, cfg_q.dot_ms};
			REG_DASH:         prdata = {20'd0, cfg_q.dash_ms};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// File: hdl/lmpc_core.sv
// Per-tick state update: timers, level, mode sequencing and channel duty patterns.
module lmpc_core import lmpc_pkg::*; #(
	parameter int CHANNELS  = DEF_CHANNELS,
	parameter int SOS_STEPS = DEF_SOS_STEPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic signed [1:0]        encoder_step,
	input  logic                     button_edge,
	input  cfg_t                     cfg,
	output logic [CHANNELS-1:0][7:0] duty_q,
	output logic [1:0]               mode_q,
	output logic [5:0]               level_q
);

	localparam logic [16:0] CH_N = 17'(CHANNELS);

	logic [15:0] press_el_q, refresh_el_q, chase_el_q, morse_el_q, hold_q;
	logic [STEP_W-1:0] step_q;

	logic [15:0] press_b, refresh_b, chase_b, morse_b;
	logic [15:0] nx_press, nx_refresh, nx_chase, nx_morse, nx_hold;
	logic [STEP_W-1:0] nx_step;
	logic [STEP_W:0] step_inc;
	logic [1:0] nx_mode, kind;
	logic [5:0] nx_level, lim;
	logic [7:0] sum;
	logic [11:0] sq;
	logic [7:0] duty_val;
	logic press, refresh_due;
	logic [CHANNELS-1:0][7:0] nx_duty;
	logic [9:0] step_s;
	logic [16:0] run, run_end;
	logic [CHANNELS:0] thr;
	logic [CHANNELS-1:0] sel, dark;

	always_comb begin
		press_b   = sat_inc(press_el_q);
		refresh_b = sat_inc(refresh_el_q);
		chase_b   = sat_inc(chase_el_q);
		morse_b   = sat_inc(morse_el_q);

		lim = (mode_q == MODE_ALL) ? cfg.all_limit : cfg.single_limit;
		sum = {2'b00, level_q} + {{6{encoder_step[1]}}, encoder_step};
		if (sum[7]) begin
			nx_level = 6'd0;
		end else if (sum > {2'b00, lim}) begin
			nx_level = lim;
		end else begin
			nx_level = sum[5:0];
		end

		nx_press = press_b;
		nx_chase = chase_b;
		nx_morse = morse_b;
		nx_step  = step_q;
		nx_hold  = hold_q;
		nx_mode  = mode_q;
		nx_duty  = duty_q;

		press = button_edge && (press_b > {6'd0, cfg.debounce_ms});
		if (press) begin
			nx_press = 16'd0;
			nx_duty  = '0;
			case (mode_q)
				MODE_SINGLE: begin
					nx_mode = MODE_ALL;
					if (nx_level > cfg.all_limit) begin
						nx_level = cfg.all_limit;
					end
				end
				MODE_ALL: begin
					nx_mode  = MODE_CHASE;
					nx_chase = 16'd0;
				end
				MODE_CHASE: begin
					nx_mode = MODE_SOS;
				end
				default: begin
					nx_mode  = MODE_SINGLE;
					nx_morse = 16'd0;
					nx_step  = '0;
				end
			endcase
		end

		sq       = nx_level * nx_level;
		duty_val = sq[11:4];

		step_s  = (cfg.chase_step_ms == 10'd0) ? 10'd1 : cfg.chase_step_ms;
		run     = CH_N * {7'd0, step_s};
		run_end = run + {5'd0, cfg.chase_gap_ms};
		thr[0]  = 1'b1;
		thr[CHANNELS] = 1'b0;
		for (int i = 1; i < CHANNELS; i++) begin
			thr[i] = {1'b0, nx_chase} > 17'(i) * {7'd0, step_s};
		end
		for (int i = 0; i < CHANNELS; i++) begin
			sel[i] = thr[i] && !thr[i+1];
		end
		for (int i = 0; i < CHANNELS; i++) begin
			dark[i] = (i == CHANNELS - 1) ? sel[0] : sel[(i+1) % CHANNELS];
		end

		kind     = sos_kind(nx_step);
		step_inc = {1'b0, nx_step} + 1'b1;

		refresh_due = refresh_b > {8'd0, cfg.refresh_ms};
		nx_refresh  = refresh_due ? 16'd0 : refresh_b;
		if (refresh_due) begin
			case (nx_mode)
				MODE_SINGLE: begin
					nx_duty[0] = duty_val;
				end
				MODE_ALL: begin
					for (int i = 0; i < CHANNELS; i++) nx_duty[i] = duty_val;
				end
				MODE_CHASE: begin
					if ({1'b0, nx_chase} > run_end) begin
						nx_chase = 16'd0;
					end else if ({1'b0, nx_chase} > run) begin
						nx_duty[CHANNELS-1] = 8'd0;
					end else begin
						for (int i = 0; i < CHANNELS; i++) begin
							if (sel[i]) begin
								nx_duty[i] = duty_val;
							end else if (dark[i]) begin
								nx_duty[i] = 8'd0;
							end
						end
					end
				end
				default: begin
					if (nx_morse > hold_q) begin
						case (kind)
							KIND_DOT:  nx_hold = {4'd0, cfg.dot_ms};
							KIND_DASH: nx_hold = {4'd0, cfg.dash_ms};
							default:   nx_hold = WORD_PAUSE_MS;
						endcase
						for (int i = 0; i < CHANNELS; i++) begin
							nx_duty[i] = nx_step[0] ? 8'd0 : duty_val;
						end
						nx_step  = (step_inc >= (STEP_W+1)'(SOS_STEPS)) ? '0 :
							step_inc[STEP_W-1:0];
						nx_morse = 16'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SINGLE;
			level_q      <= LEVEL_RESET;
			press_el_q   <= 16'd0;
			refresh_el_q <= 16'd0;
			chase_el_q   <= 16'd0;
			morse_el_q   <= 16'd0;
			step_q       <= '0;
			hold_q       <= 16'd0;
			duty_q       <= '0;
		end else if (advance) begin
			mode_q       <= nx_mode;
			level_q      <= nx_level;
			press_el_q   <= nx_press;
			refresh_el_q <= nx_refresh;
			chase_el_q   <= nx_chase;
			morse_el_q   <= nx_morse;
			step_q       <= nx_step;
			hold_q       <= nx_hold;
			duty_q       <= nx_duty;
		end
	end

endmodule

// File: hdl/lamp_mode_pattern_controller.sv
// Top level of the lamp mode and pattern controller: input register, result handshake, ports.
//
// Each input transaction is one millisecond tick carrying an encoder step and a button
// edge; each tick produces exactly one result transaction with the five channel duties,
// the current mode and the brightness level.
// A tick is taken into an input register, then processed in a single pass whose outcome
// is written into the state registers, which also serve as the result register.
// One tick is accepted per cycle while item_ready is high.
// The input register keeps accepting while a result waits, so one tick can be held
// when the receiver stalls; item_ready drops only when both stages are full.
// Configuration is written through the APB-style port at byte address 4*index; the user
// must do so while the block is idle, which the block does not enforce; pready is always
// high and reads return the register value. Reset restores the register defaults, single
// mode, level 4, all timers cleared and all duties zero, and leaves both channels empty.
module lamp_mode_pattern_controller import lmpc_pkg::*; #(
	parameter int CHANNELS  = DEF_CHANNELS,
	parameter int SOS_STEPS = DEF_SOS_STEPS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic signed [1:0]     encoder_step,
	input  logic                  button_edge,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [7:0]            duty_one,
	output logic [7:0]            duty_two,
	output logic [7:0]            duty_three,
	output logic [7:0]            duty_four,
	output logic [7:0]            duty_five,
	output logic [1:0]            current_mode,
	output logic [5:0]            level
);

	cfg_t cfg;
	logic valid_s1, result_valid_q, advance;
	logic signed [1:0] enc_s1;
	logic btn_s1;
	logic [CHANNELS-1:0][7:0] duty_q;
	logic [4:0][7:0] duty_rep;

	assign pready       = 1'b1;
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			enc_s1 <= encoder_step;
			btn_s1 <= button_edge;
		end
	end

	lmpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lmpc_core #(
		.CHANNELS  (CHANNELS),
		.SOS_STEPS (SOS_STEPS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.encoder_step (enc_s1),
		.button_edge  (btn_s1),
		.cfg          (cfg),
		.duty_q       (duty_q),
		.mode_q       (current_mode),
		.level_q      (level)
	);

	for (genvar g = 0; g < 5; g++) begin : g_rep
		if (g < CHANNELS) begin : g_on
			assign duty_rep[g] = duty_q[g];
		end else begin : g_off
			assign duty_rep[g] = 8'd0;
		end
	end

	assign duty_one   = duty_rep[0];
	assign duty_two   = duty_rep[1];
	assign duty_three = duty_rep[2];
	assign duty_four  = duty_rep[3];
	assign duty_five  = duty_rep[4];

	a_hold_without_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(current_mode) && $stable(level))
		else $error("result state changed without a tick moving through");

	a_mode_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (current_mode == $past(current_mode)) ||
			(current_mode == $past(current_mode) + 2'd1))
		else $error("mode skipped a step of its cycle");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("input stalled while a stage had room");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the lamp mode and pattern controller with a tick-level scoreboard.
module testbench;
	import lmpc_pkg::*;

	localparam int NCH            = DEF_CHANNELS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_LEN   = 80;

	typedef struct packed {
		logic [4:0][7:0] duty;
		logic [1:0]      mode;
		logic [5:0]      lvl;
	} lamp_outputs_t;

	class lamp_scoreboard;
		cfg_t            cfg;
		logic [1:0]      mode;
		logic [5:0]      lvl;
		logic [15:0]     press_t;
		logic [15:0]     refresh_t;
		logic [15:0]     chase_t;
		logic [15:0]     morse_t;
		logic [15:0]     morse_hold;
		logic [4:0]      morse_idx;
		logic [4:0][7:0] duty;
		lamp_outputs_t   expected_outputs[$];
		int              failures;

		function new();
			cfg.single_limit  = RST_SINGLE_LIMIT;
			cfg.all_limit     = RST_ALL_LIMIT;
			cfg.chase_step_ms = RST_CHASE_STEP;
			cfg.chase_gap_ms  = RST_CHASE_GAP;
			cfg.debounce_ms   = RST_DEBOUNCE;
			cfg.refresh_ms    = RST_REFRESH;
			cfg.dot_ms        = RST_DOT;
			cfg.dash_ms       = RST_DASH;
			mode = MODE_SINGLE;
			lvl = LEVEL_RESET;
			press_t = 0;
			refresh_t = 0;
			chase_t = 0;
			morse_t = 0;
			morse_hold = 0;
			morse_idx = 0;
			duty = '0;
			failures = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_SINGLE_LIMIT: cfg.single_limit  = v[5:0];
				REG_ALL_LIMIT:    cfg.all_limit     = v[5:0];
				REG_CHASE_STEP:   cfg.chase_step_ms = v[9:0];
				REG_CHASE_GAP:    cfg.chase_gap_ms  = v[11:0];
				REG_DEBOUNCE:     cfg.debounce_ms   = v[9:0];
				REG_REFRESH:      cfg.refresh_ms    = v[7:0];
				REG_DOT:          cfg.dot_ms        = v[11:0];
				default:          cfg.dash_ms       = v[11:0];
			endcase
		endfunction

		function logic [31:0] register_value(logic [2:0] idx);
			case (idx)
				REG_SINGLE_LIMIT: return {26'd0, cfg.single_limit};
				REG_ALL_LIMIT:    return {26'd0, cfg.all_limit};
				REG_CHASE_STEP:   return {22'd0, cfg.chase_step_ms};
				REG_CHASE_GAP:    return {20'd0, cfg.chase_gap_ms};
				REG_DEBOUNCE:     return {22'd0, cfg.debounce_ms};
				REG_REFRESH:      return {24'd0, cfg.refresh_ms};
				REG_DOT:          return {20'd0, cfg.dot_ms};
				default:          return {20'd0, cfg.dash_ms};
			endcase
		endfunction

		function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic [15:0] sos_hold(logic [4:0] idx);
			int p;
			p = idx % PATTERN_LEN;
			case (p)
				5, 6, 8, 10, 11: return {4'd0, cfg.dash_ms};
				17: return WORD_PAUSE_MS;
				default: return {4'd0, cfg.dot_ms};
			endcase
		endfunction

		function void take_tick(logic signed [1:0] step, logic pressed);
			int lv, lim, dv, s, t, run, k, prev;
			lamp_outputs_t o;
			press_t = bump(press_t);
			refresh_t = bump(refresh_t);
			chase_t = bump(chase_t);
			morse_t = bump(morse_t);

			lim = (mode == MODE_ALL) ? cfg.all_limit : cfg.single_limit;
			lv = lvl;
			lv = lv + step;
			if (lv < 0)
				lv = 0;
			if (lv > lim)
				lv = lim;
			lvl = lv[5:0];

			if (pressed && press_t > cfg.debounce_ms) begin
				press_t = 0;
				duty = '0;
				case (mode)
					MODE_SINGLE: begin
						mode = MODE_ALL;
						if (lvl > cfg.all_limit)
							lvl = cfg.all_limit;
					end
					MODE_ALL: begin
						mode = MODE_CHASE;
						chase_t = 0;
					end
					MODE_CHASE: begin
						mode = MODE_SOS;
					end
					default: begin
						mode = MODE_SINGLE;
						morse_t = 0;
						morse_idx = 0;
					end
				endcase
			end

			if (refresh_t > cfg.refresh_ms) begin
				lv = lvl;
				dv = (lv * lv) / 16;
				refresh_t = 0;
				case (mode)
					MODE_SINGLE: begin
						duty[0] = dv[7:0];
					end
					MODE_ALL: begin
						for (int i = 0; i < NCH; i++)
							duty[i] = dv[7:0];
					end
					MODE_CHASE: begin
						s = (cfg.chase_step_ms == 0) ? 1 : cfg.chase_step_ms;
						t = chase_t;
						run = NCH * s;
						if (t > run + cfg.chase_gap_ms) begin
							chase_t = 0;
						end else if (t > run) begin
							duty[NCH-1] = 0;
						end else begin
							k = (t == 0) ? 0 : (t - 1) / s;
							if (k >= NCH)
								k = NCH - 1;
							prev = (k == 0) ? NCH - 1 : k - 1;
							duty[prev] = 0;
							duty[k] = dv[7:0];
						end
					end
					default: begin
						if (morse_t > morse_hold) begin
							morse_hold = sos_hold(morse_idx);
							for (int i = 0; i < NCH; i++)
								duty[i] = morse_idx[0] ? 8'd0 : dv[7:0];
							morse_idx = (morse_idx + 5'd1 >= DEF_SOS_STEPS) ? 5'd0 : morse_idx + 5'd1;
							morse_t = 0;
						end
					end
				endcase
			end

			o.duty = duty;
			o.mode = mode;
			o.lvl = lvl;
			expected_outputs.push_back(o);
		endfunction

		function void note_mismatch(string what, int unsigned want, int unsigned seen);
			failures++;
			if (failures <= 10)
				$display("mismatch in %s: expected %0d, got %0d", what, want, seen);
		endfunction

		function void check_outputs(lamp_outputs_t seen);
			lamp_outputs_t want;
			if (expected_outputs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result transaction: mode %0d level %0d",
						seen.mode, seen.lvl);
				return;
			end
			want = expected_outputs.pop_front();
			for (int i = 0; i < NCH; i++)
				if (want.duty[i] !== seen.duty[i])
					note_mismatch($sformatf("duty of channel %0d", i + 1),
						want.duty[i], seen.duty[i]);
			if (want.mode !== seen.mode)
				note_mismatch("current_mode", want.mode, seen.mode);
			if (want.lvl !== seen.lvl)
				note_mismatch("level", want.lvl, seen.lvl);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic signed [1:0]     encoder_step = '0;
	logic                  button_edge = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [7:0]            duty_one, duty_two, duty_three, duty_four, duty_five;
	logic [1:0]            current_mode;
	logic [5:0]            level;

	lamp_scoreboard sb = new();
	lamp_outputs_t  observed;
	int             idle_pct = 37;
	int             hold_off = 0;
	int             quiet_cycles = 0;

	lamp_mode_pattern_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.encoder_step(encoder_step), .button_edge(button_edge),
		.result_valid(result_valid), .result_ready(result_ready),
		.duty_one(duty_one), .duty_two(duty_two), .duty_three(duty_three),
		.duty_four(duty_four), .duty_five(duty_five),
		.current_mode(current_mode), .level(level)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver holds off for a counted stretch on request, else stalls at random.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_ready = 1'b0;
				hold_off--;
			end else begin
				result_ready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			observed.duty = {duty_five, duty_four, duty_three, duty_two, duty_one};
			observed.mode = current_mode;
			observed.lvl = level;
			sb.check_outputs(observed);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic send_tick(input logic signed [1:0] step, input logic pressed);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		encoder_step = step;
		button_edge = pressed;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.take_tick(step, pressed);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr)
			sb.set_register(idx, data);
		else if (prdata !== sb.register_value(idx))
			sb.note_mismatch($sformatf("read of register %0d", idx),
				sb.register_value(idx), prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_registers();
		for (int i = 0; i < 8; i++)
			apb_access(3'(i), 1'b0, 32'd0);
	endtask

	task automatic write_config(input int unsigned single_lim, input int unsigned all_lim,
			input int unsigned chase_step, input int unsigned chase_gap,
			input int unsigned debounce, input int unsigned refresh,
			input int unsigned dot, input int unsigned dash);
		item_valid = 1'b0;
		while (sb.expected_outputs.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
		apb_access(REG_SINGLE_LIMIT, 1'b1, single_lim);
		apb_access(REG_ALL_LIMIT, 1'b1, all_lim);
		apb_access(REG_CHASE_STEP, 1'b1, chase_step);
		apb_access(REG_CHASE_GAP, 1'b1, chase_gap);
		apb_access(REG_DEBOUNCE, 1'b1, debounce);
		apb_access(REG_REFRESH, 1'b1, refresh);
		apb_access(REG_DOT, 1'b1, dot);
		apb_access(REG_DASH, 1'b1, dash);
		check_registers();
	endtask

	// Presses mostly come just after the debounce window so that all four modes are
	// visited; a few stray presses land anywhere.  The level climbs or falls in runs.
	task automatic run_ticks(input int count, input int press_span, input int idle,
			input bit pressure);
		int since_press, next_press, r;
		bit climbing;
		logic signed [1:0] step;
		logic pressed;
		since_press = 0;
		next_press = sb.cfg.debounce_ms + 1 + $urandom_range(press_span);
		climbing = 1'b1;
		idle_pct = idle;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0)
				climbing = ($urandom_range(99) < 60);
			r = $urandom_range(99);
			if (climbing)
				step = (r < 60) ? 2'sd1 : (r < 75) ? 2'sd0 : (r < 90) ? -2'sd1 : -2'sd2;
			else
				step = (r < 25) ? 2'sd1 : (r < 50) ? 2'sd0 : (r < 75) ? -2'sd1 : -2'sd2;
			since_press++;
			if (since_press >= next_press) begin
				pressed = 1'b1;
				since_press = 0;
				next_press = sb.cfg.debounce_ms + 1 + $urandom_range(press_span);
			end else begin
				pressed = ($urandom_range(99) < 3);
			end
			if (pressure && n == count / 2)
				hold_off = HOLD_OFF_LEN;
			send_tick(step, pressed);
		end
		item_valid = 1'b0;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		check_registers();

		// Reset settings: a press inside the debounce window is ignored.
		send_tick(2'sd1, 1'b1);
		send_tick(-2'sd2, 1'b0);
		send_tick(2'sd0, 1'b0);

		// Zero chase step, no debounce and a refresh on every tick.
		write_config(63, 44, 0, 1, 0, 0, 1, 2);
		send_tick(2'sd1, 1'b0);
		send_tick(-2'sd2, 1'b0);
		send_tick(-2'sd1, 1'b0);
		send_tick(2'sd0, 1'b0);
		send_tick(2'sd1, 1'b1);
		send_tick(2'sd1, 1'b0);
		send_tick(2'sd1, 1'b1);
		repeat (6) send_tick(2'sd0, 1'b0);
		send_tick(2'sd0, 1'b1);
		repeat (7) send_tick(2'sd1, 1'b0);
		send_tick(-2'sd2, 1'b1);
		send_tick(-2'sd2, 1'b0);
		send_tick(-2'sd2, 1'b0);

		write_config(63, 44, 3, 4, 2, 0, 1, 2);
		run_ticks(200, 60, 37, 1'b0);
		write_config(10, 5, 1, 0, 0, 1, 1, 1);
		run_ticks(150, 30, 37, 1'b0);
		write_config(0, 0, 0, 0, 0, 0, 1, 1);
		run_ticks(150, 20, 0, 1'b1);
		write_config(63, 63, 1023, 4095, 1023, 255, 4095, 4095);
		run_ticks(120, 10, 37, 1'b0);
		write_config(40, 63, 2, 3, 5, 2, 2, 3);
		run_ticks(250, 80, 37, 1'b0);
		write_config(63, 44, 5, 10, 1, 0, 3, 5);
		run_ticks(300, 150, 37, 1'b1);
		write_config($urandom_range(63), $urandom_range(63), $urandom_range(6),
			$urandom_range(15), $urandom_range(20), $urandom_range(3),
			$urandom_range(6, 1), $urandom_range(8, 1));
		run_ticks(150, 60, 37, 1'b0);

		while (sb.expected_outputs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.expected_outputs.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
